// ----- design/dti_pkg.sv -----
package dti_pkg;

   // Default sizes of the node table, the feature store and the walk bound.
   localparam int NODE_COUNT_DEF    = 256;
   localparam int FEATURE_COUNT_DEF = 32;
   localparam int MAX_WALK_DEF      = 32;

   // Fixed widths of the request and response fields.
   localparam int MODE_W   = 2;
   localparam int NODE_W   = 8;
   localparam int FEAT_W   = 5;
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 8;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE_NODE    = 2'd0,
      MODE_WRITE_FEATURE = 2'd1,
      MODE_CLASSIFY      = 2'd2,
      MODE_NONE          = 2'd3
   } mode_type;

   // Walk sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NODE,
      ST_FEAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [NODE_W-1:0]         node_index;
      logic                      node_is_leaf;
      logic [FEAT_W-1:0]         split_feature;
      logic signed [VALUE_W-1:0] split_threshold;
      logic [NODE_W-1:0]         left_index;
      logic [NODE_W-1:0]         right_index;
      logic [ACTION_W-1:0]       leaf_action;
      logic [FEAT_W-1:0]         feature_index;
      logic signed [VALUE_W-1:0] feature_value;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                fault;
   } rsp_type;

   // One entry of the node table (62 bits).
   typedef struct packed {
      logic                      node_is_leaf;
      logic [FEAT_W-1:0]         split_feature;
      logic signed [VALUE_W-1:0] split_threshold;
      logic [NODE_W-1:0]         left_index;
      logic [NODE_W-1:0]         right_index;
      logic [ACTION_W-1:0]       leaf_action;
   } node_type;

endpackage

// ----- design/decision_tree_inference.sv -----
// Binary decision tree classifier.
// Requests arrive on req_valid/req_ready with a req_type payload. A request
// in write-node mode stores one node table entry, one in write-feature mode
// stores one feature of the current sample; neither gives a response.
// A classify request walks the tree from node 0 and gives one
// response on rsp_valid/rsp_ready: the action of the leaf reached, or a
// fault with action 0 when the walk exceeds MAX_WALK comparisons or points
// to a child beyond the table. Mode 3 is accepted and ignored.
// The node table and the feature store are synchronous memories with a
// registered read port. Each inner node passes through a node read, then a
// feature read and compare, and no request is taken from the start of a
// classify walk until its result is loaded into the output register.
// The response sits in an output register: write requests are still taken
// while it waits. A finished walk holds its result until the register is
// free, and no request is taken meanwhile.
// Reset clears the sequencer and the response valid. Memory contents are
// undefined until written.
module decision_tree_inference #(
   parameter int NODE_COUNT    = dti_pkg::NODE_COUNT_DEF,
   parameter int FEATURE_COUNT = dti_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_WALK      = dti_pkg::MAX_WALK_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dti_pkg::rsp_type rsp_data
);
   import dti_pkg::*;

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int STEP_W  = $clog2(MAX_WALK + 1);

   // Storage.
   node_type             node_table_ff    [NODE_COUNT];
   logic [VALUE_W-1:0]   feature_store_ff [FEATURE_COUNT];
   node_type             node_q_ff;
   logic [VALUE_W-1:0]   feat_q_ff;
   logic                 feat_oob_ff;
   logic                 feat_oob_in;

   // Sequencer and result registers.
   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   rsp_type              result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   // Combinational control.
   logic                 req_accept;
   mode_type             req_mode;
   logic [31:0]          node_idx_ext;
   logic [31:0]          feat_idx_ext;
   logic [31:0]          split_ext;
   logic [31:0]          child_ext;
   logic                 node_wr_en;
   logic                 feat_wr_en;
   logic                 node_rd_en;
   logic [NODE_AW-1:0]   node_rd_addr;
   logic                 feat_rd_en;
   logic [FEAT_AW-1:0]   feat_rd_addr;
   logic                 walk_limit;
   logic                 go_left;
   logic [NODE_W-1:0]    next_child;
   logic                 child_oob;
   logic [VALUE_W-1:0]   feat_val;
   logic                 res_set;
   logic                 res_load;
   rsp_type              res_value;

   assign req_accept = req_valid && req_ready;
   assign req_mode   = mode_type'(req_data.mode);

   // Index range checks on the write ports.
   assign node_idx_ext = 32'(req_data.node_index);
   assign feat_idx_ext = 32'(req_data.feature_index);
   assign node_wr_en   = req_accept && (req_mode == MODE_WRITE_NODE) &&
                         (node_idx_ext < 32'(NODE_COUNT));
   assign feat_wr_en   = req_accept && (req_mode == MODE_WRITE_FEATURE) &&
                         (feat_idx_ext < 32'(FEATURE_COUNT));

   // Feature lookup for the current inner node; an index beyond the store
   // reads as zero.
   assign split_ext    = 32'(node_q_ff.split_feature);
   assign feat_oob_in  = !(split_ext < 32'(FEATURE_COUNT));
   assign feat_rd_addr = feat_oob_in ? '0 : split_ext[FEAT_AW-1:0];

   // Compare and child selection once the feature value is back.
   assign walk_limit = (32'(steps_ff) >= 32'(MAX_WALK));
   assign feat_val   = feat_oob_ff ? '0 : feat_q_ff;
   assign go_left    = ($signed(feat_val) <= $signed(node_q_ff.split_threshold));
   assign next_child = go_left ? node_q_ff.left_index : node_q_ff.right_index;
   assign child_ext  = 32'(next_child);
   assign child_oob  = !(child_ext < 32'(NODE_COUNT));

   // Node table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_table_ff[node_idx_ext[NODE_AW-1:0]] <= node_type'{
            node_is_leaf:    req_data.node_is_leaf,
            split_feature:   req_data.split_feature,
            split_threshold: req_data.split_threshold,
            left_index:      req_data.left_index,
            right_index:     req_data.right_index,
            leaf_action:     req_data.leaf_action
         };
      end
      if (node_rd_en) begin
         node_q_ff <= node_table_ff[node_rd_addr];
      end
   end

   // Feature store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (feat_wr_en) begin
         feature_store_ff[feat_idx_ext[FEAT_AW-1:0]] <= req_data.feature_value;
      end
      if (feat_rd_en) begin
         feat_q_ff   <= feature_store_ff[feat_rd_addr];
         feat_oob_ff <= feat_oob_in;
      end
   end

   // Next state of the walk sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_CLASSIFY)) begin
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            if (node_q_ff.node_is_leaf || walk_limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FEAT;
            end
         end
         ST_FEAT: begin
            if (child_oob) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_NODE;
            end
         end
         ST_DONE: begin
            if (res_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: memory reads, step count and result capture.
   always_comb begin
      req_ready    = 1'b0;
      node_rd_en   = 1'b0;
      node_rd_addr = '0;
      feat_rd_en   = 1'b0;
      steps_in     = steps_ff;
      res_set      = 1'b0;
      res_value    = '{action: '0, fault: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_accept && (req_mode == MODE_CLASSIFY)) begin
               node_rd_en = 1'b1;
               steps_in   = '0;
            end
         end
         ST_NODE: begin
            if (node_q_ff.node_is_leaf) begin
               res_set   = 1'b1;
               res_value = '{action: node_q_ff.leaf_action, fault: 1'b0};
            end else if (walk_limit) begin
               res_set = 1'b1;
            end else begin
               feat_rd_en = 1'b1;
            end
         end
         ST_FEAT: begin
            steps_in = steps_ff + 1'b1;
            if (child_oob) begin
               res_set = 1'b1;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = child_ext[NODE_AW-1:0];
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // The held result moves to the output register once that is free.
   assign res_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign result_in    = res_set ? res_value : result_ff;
   assign rsp_valid_in = res_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      steps_ff  <= steps_in;
      result_ff <= result_in;
      if (res_load) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The step count never passes the walk bound while walking.
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE || state_ff == ST_FEAT) |-> (32'(steps_ff) <= 32'(MAX_WALK)))
      else $error("walk step count beyond bound");

   // A faulted response always carries action zero.
   a_fault_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fault) |-> (rsp_data.action == '0))
      else $error("fault response with nonzero action");

   // A feature read is always followed by the compare cycle.
   a_feat_then_cmp: assert property (@(posedge clock) disable iff (reset)
      feat_rd_en |=> (state_ff == ST_FEAT))
      else $error("feature read not followed by compare");

   // A result never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // Memory writes happen only while the sequencer is idle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (node_wr_en || feat_wr_en) |-> (state_ff == ST_IDLE))
      else $error("memory write during a walk");

endmodule
